### hw/rtl/dlp_pkg.sv
// Shared types and constants for the decimal list parser.
// No dependencies.
package dlp_pkg;

    localparam int unsigned MAX_VALUES = 8;
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;
    localparam logic [7:0]  CHAR_EOL   = 8'h00;
    localparam logic [19:0] VALUE_LIMIT = 20'd65535;

    typedef struct packed {
        logic [15:0] freq_value;
        logic [5:0]  slot_index;
        logic [6:0]  value_count;
        logic        line_done;
    } t_result;

    // up to two results per character; when only one, it sits in slot a
    typedef struct packed {
        logic    a_vld;
        logic    b_vld;
        t_result a;
        t_result b;
    } t_res_pair;

endpackage

### hw/rtl/dlp_token.sv
// Per-character token logic: accumulator, flags, accepted count.
// Depends on dlp_pkg.
module dlp_token (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_char,
    output dlp_pkg::t_res_pair o_pair
);

    logic [15:0] r_accum;
    logic        r_has_digits;
    logic        r_ovf;
    logic [6:0]  r_count;

    logic [15:0] n_accum;
    logic        n_has_digits;
    logic        n_ovf;
    logic [6:0]  n_count;

    logic        is_digit;
    logic        is_eol;
    logic        take;
    logic [19:0] mac;
    logic [6:0]  count_inc;

    assign is_digit  = (i_char >= dlp_pkg::CHAR_ZERO) && (i_char <= dlp_pkg::CHAR_NINE);
    assign is_eol    = (i_char == dlp_pkg::CHAR_EOL);
    // x*10 = x*8 + x*2
    assign mac       = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                     + {16'd0, i_char[3:0]};
    assign take      = r_has_digits && !r_ovf && (r_accum != 16'd0)
                     && (r_count < 7'(dlp_pkg::MAX_VALUES));
    assign count_inc = r_count + 7'd1;

    always_comb begin
        n_accum      = r_accum;
        n_has_digits = r_has_digits;
        n_ovf        = r_ovf;
        n_count      = r_count;

        o_pair = '0;

        if (is_digit) begin
            n_has_digits = 1'b1;
            if (!r_ovf) begin
                n_accum = mac[15:0];
                n_ovf   = (mac > dlp_pkg::VALUE_LIMIT);
            end
        end else begin
            n_accum      = 16'd0;
            n_has_digits = 1'b0;
            n_ovf        = 1'b0;
            if (take) begin
                o_pair.a_vld         = 1'b1;
                o_pair.a.freq_value  = r_accum;
                o_pair.a.slot_index  = r_count[5:0];
                o_pair.a.value_count = count_inc;
                n_count              = count_inc;
            end
            if (is_eol) begin
                // summary goes after the value word if there is one
                if (take) begin
                    o_pair.b_vld         = 1'b1;
                    o_pair.b.value_count = count_inc;
                    o_pair.b.line_done   = 1'b1;
                end else begin
                    o_pair.a_vld         = 1'b1;
                    o_pair.a.value_count = r_count;
                    o_pair.a.line_done   = 1'b1;
                end
                n_count = 7'd0;
            end
        end

        if (!i_fire) begin
            o_pair.a_vld = 1'b0;
            o_pair.b_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum      <= 16'd0;
            r_has_digits <= 1'b0;
            r_ovf        <= 1'b0;
            r_count      <= 7'd0;
        end else if (i_fire) begin
            r_accum      <= n_accum;
            r_has_digits <= n_has_digits;
            r_ovf        <= n_ovf;
            r_count      <= n_count;
        end
    end

endmodule

### hw/rtl/dlp_out_fifo.sv
// Result queue: takes up to two words per cycle, hands out one.
// Depends on dlp_pkg.
module dlp_out_fifo (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dlp_pkg::t_res_pair                   i_pair,
    input  logic                                 i_pop,
    output logic                                 o_valid,
    output logic                                 o_room2,
    output logic [dlp_pkg::FIFO_CNT_W-1:0]       o_level,
    output dlp_pkg::t_result                     o_data
);

    dlp_pkg::t_result                  r_mem [dlp_pkg::FIFO_DEPTH];
    logic [dlp_pkg::FIFO_PTR_W-1:0]    r_wr_ptr;
    logic [dlp_pkg::FIFO_PTR_W-1:0]    r_rd_ptr;
    logic [dlp_pkg::FIFO_CNT_W-1:0]    r_count;

    logic [dlp_pkg::FIFO_PTR_W-1:0]    wr_ptr1;
    logic                              pop;
    logic [dlp_pkg::FIFO_CNT_W-1:0]    n_pushes;

    assign wr_ptr1  = r_wr_ptr + dlp_pkg::FIFO_PTR_W'(1);
    assign pop      = i_pop && (r_count != '0);
    assign n_pushes = dlp_pkg::FIFO_CNT_W'(i_pair.a_vld) + dlp_pkg::FIFO_CNT_W'(i_pair.b_vld);

    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign o_level  = r_count;
    assign o_room2  = (r_count <= dlp_pkg::FIFO_CNT_W'(dlp_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_pair.a_vld) begin
            r_mem[r_wr_ptr] <= i_pair.a;
        end
        if (i_pair.b_vld) begin
            r_mem[wr_ptr1] <= i_pair.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + n_pushes[dlp_pkg::FIFO_PTR_W-1:0];
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + dlp_pkg::FIFO_PTR_W'(1);
            end
            r_count <= r_count + n_pushes - dlp_pkg::FIFO_CNT_W'(pop);
        end
    end

endmodule

### hw/rtl/decimal_list_parser_core.sv
// Decimal list parser top: input register, token logic, result queue.
// An accepted character is registered in the input register; its words are then registered into the result queue.
// Throughput: one character per cycle when not stalled; a line end after a value yields two words.
// Input stalls while the character register waits for two free queue slots.
// Reset (i_rst_n low, synchronous) clears token state, count and queue.
module decimal_list_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_char_code,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_freq_value,
    output logic [5:0]  o_slot_index,
    output logic [6:0]  o_value_count,
    output logic        o_line_done
);

    logic       r_in_valid;
    logic [7:0] r_in_char;

    logic                                fire;
    logic                                room2;
    logic [dlp_pkg::FIFO_CNT_W-1:0]      level;
    dlp_pkg::t_res_pair                  pair;
    dlp_pkg::t_result                    head;

    assign fire    = r_in_valid && room2;
    assign o_stall = r_in_valid && !room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_char <= i_char_code;
        end
    end

    dlp_token u_token (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_in_char),
        .o_pair  (pair)
    );

    dlp_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (pair),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_room2 (room2),
        .o_level (level),
        .o_data  (head)
    );

    assign o_freq_value  = head.freq_value;
    assign o_slot_index  = head.slot_index;
    assign o_value_count = head.value_count;
    assign o_line_done   = head.line_done;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= dlp_pkg::FIFO_CNT_W'(dlp_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pair.b_vld |-> (pair.a_vld && pair.b.line_done && !pair.a.line_done))
        else $error("second word must be the line summary after a value");

    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_line_done) |-> (o_freq_value == 16'd0 && o_slot_index == 6'd0))
        else $error("summary word carries a value");

    a_no_fire_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (level > dlp_pkg::FIFO_CNT_W'(dlp_pkg::FIFO_DEPTH - 2)) |-> !pair.a_vld)
        else $error("push into queue without room");
`endif

endmodule

### sim/tb_decimal_list_parser_core.sv
`timescale 1ns / 100ps
// Testbench for decimal_list_parser_core: drives character streams and checks each word.
// Expected words come from a local line parser; needs dlp_pkg and the core RTL.
module tb_decimal_list_parser_core;

    localparam logic [7:0] SEP_COMMA = 8'h2C;
    localparam logic [7:0] SEP_SPACE = 8'h20;
    localparam logic [7:0] SEP_TAB   = 8'h09;
    localparam int RAND_PER_PHASE = 550;
    localparam int CYCLE_LIMIT    = 300000;

    typedef struct packed {
        logic [7:0]       ch;
        logic             typed;      // words below are the expectation, not the parser
        logic [1:0]       n_words;
        dlp_pkg::t_result w0;
        dlp_pkg::t_result w1;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic [7:0]  i_char_code;
    logic        o_stall;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_freq_value;
    logic [5:0]  o_slot_index;
    logic [6:0]  o_value_count;
    logic        o_line_done;

    // parser state
    logic [15:0] tok_value;
    logic        tok_digits;
    logic        tok_overflow;
    logic [6:0]  line_values;

    dlp_pkg::t_result parsed_words[$];
    t_dir_row         dir_rows[$];
    logic [7:0]       line_chars[$];
    int               err_cnt = 0;
    int               cycles = 0;
    int               send_idle_pct;
    int               recv_idle_pct;

    decimal_list_parser_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_char_code  (i_char_code),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_freq_value (o_freq_value),
        .o_slot_index (o_slot_index),
        .o_value_count(o_value_count),
        .o_line_done  (o_line_done)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("** decimal_list_parser_core: FAILED **");
            $finish;
        end
    end

    function automatic dlp_pkg::t_result mk_res(input logic [15:0] v, input logic [5:0] s,
                                                input logic [6:0] c, input logic d);
        dlp_pkg::t_result r;
        r.freq_value  = v;
        r.slot_index  = s;
        r.value_count = c;
        r.line_done   = d;
        return r;
    endfunction

    function automatic t_dir_row mk_row(input logic [7:0] ch, input logic typed,
                                        input logic [1:0] n, input dlp_pkg::t_result w0,
                                        input dlp_pkg::t_result w1);
        t_dir_row r;
        r.ch      = ch;
        r.typed   = typed;
        r.n_words = n;
        r.w0      = w0;
        r.w1      = w1;
        return r;
    endfunction

    // one character through the line parser; returns up to two words
    function automatic void parse_char(input logic [7:0] ch, output int n,
                                       output dlp_pkg::t_result w0,
                                       output dlp_pkg::t_result w1);
        logic [19:0]      next_val;
        dlp_pkg::t_result tmp;
        n  = 0;
        w0 = '0;
        w1 = '0;
        if (ch >= dlp_pkg::CHAR_ZERO && ch <= dlp_pkg::CHAR_NINE) begin
            tok_digits = 1'b1;
            if (!tok_overflow) begin
                next_val = tok_value * 20'd10 + (ch - dlp_pkg::CHAR_ZERO);
                if (next_val > dlp_pkg::VALUE_LIMIT)
                    tok_overflow = 1'b1;
                tok_value = next_val[15:0];
            end
            return;
        end
        if (tok_digits && !tok_overflow && tok_value != 16'd0
                && line_values < 7'(dlp_pkg::MAX_VALUES)) begin
            w0 = mk_res(tok_value, line_values[5:0], line_values + 7'd1, 1'b0);
            line_values = line_values + 7'd1;
            n = 1;
        end
        tok_value    = '0;
        tok_digits   = 1'b0;
        tok_overflow = 1'b0;
        if (ch == dlp_pkg::CHAR_EOL) begin
            tmp = mk_res(16'd0, 6'd0, line_values, 1'b1);
            if (n == 0)
                w0 = tmp;
            else
                w1 = tmp;
            n++;
            line_values = '0;
        end
    endfunction

    function automatic logic [7:0] pick_sep();
        logic [7:0] c;
        case ($urandom_range(3))
            0: c = SEP_COMMA;
            1: c = SEP_SPACE;
            2: c = SEP_TAB;
            default: begin
                do c = 8'($urandom_range(1, 255));
                while (c >= dlp_pkg::CHAR_ZERO && c <= dlp_pkg::CHAR_NINE);
            end
        endcase
        return c;
    endfunction

    task automatic push_number(input int unsigned v);
        logic [7:0] digs[$];
        do begin
            digs.push_front(8'(dlp_pkg::CHAR_ZERO + v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digs[i]) line_chars.push_back(digs[i]);
    endtask

    task automatic build_line();
        int ntok;
        line_chars = {};
        if ($urandom_range(4) == 0) begin
            // noise: any bytes, digits and zeros included
            repeat ($urandom_range(1, 30)) line_chars.push_back(8'($urandom_range(255)));
        end else begin
            ntok = $urandom_range(0, 12);
            if ($urandom_range(3) == 0)
                line_chars.push_back(pick_sep());
            for (int t = 0; t < ntok; t++) begin
                if ($urandom_range(4) == 0)
                    repeat ($urandom_range(1, 2)) line_chars.push_back(dlp_pkg::CHAR_ZERO);
                case ($urandom_range(9))
                    0: repeat ($urandom_range(1, 3)) line_chars.push_back(dlp_pkg::CHAR_ZERO);
                    1: push_number(65530 + $urandom_range(11));
                    2: push_number($urandom_range(65536, 9999999));
                    3, 4, 5: push_number($urandom_range(1, 999));
                    6, 7, 8: push_number($urandom_range(1, 65535));
                    default: begin
                        repeat ($urandom_range(1, 8))
                            line_chars.push_back(8'(dlp_pkg::CHAR_ZERO + $urandom_range(9)));
                    end
                endcase
                // last token sometimes runs straight into the line end
                if (t != ntok - 1 || $urandom_range(1) == 0)
                    repeat ($urandom_range(1, 2)) line_chars.push_back(pick_sep());
            end
        end
        line_chars.push_back(dlp_pkg::CHAR_EOL);
    endtask

    // entered and left at a falling edge; valid stays up if the next character follows at once
    task automatic send_row(input t_dir_row row);
        int               n;
        dlp_pkg::t_result w0;
        dlp_pkg::t_result w1;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= row.ch;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_char(row.ch, n, w0, w1);
        if (row.typed) begin
            n  = row.n_words;
            w0 = row.w0;
            w1 = row.w1;
        end
        if (n > 0) parsed_words.push_back(w0);
        if (n > 1) parsed_words.push_back(w1);
        @(negedge i_clk);
    endtask

    function automatic void check_field(input string fname, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, exp_v, got_v);
            err_cnt++;
        end
    endfunction

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin : word_check
        dlp_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (parsed_words.size() == 0) begin
                $display("%0t: unexpected word: value=%0d slot=%0d count=%0d done=%0d",
                         $time, o_freq_value, o_slot_index, o_value_count, o_line_done);
                err_cnt++;
            end else begin
                want = parsed_words.pop_front();
                check_field("freq_value", want.freq_value, o_freq_value);
                check_field("slot_index", want.slot_index, o_slot_index);
                check_field("value_count", want.value_count, o_value_count);
                check_field("line_done", want.line_done, o_line_done);
            end
        end
    end

    initial begin
        int sent;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_char_code   = 8'h00;
        send_idle_pct = 29;
        recv_idle_pct = 63;
        tok_value     = '0;
        tok_digits    = 1'b0;
        tok_overflow  = 1'b0;
        line_values   = '0;

        // empty line right after reset: summary only
        dir_rows.push_back(mk_row(dlp_pkg::CHAR_EOL, 1'b1, 2'd1,
                                  mk_res(16'd0, 6'd0, 7'd0, 1'b1), '0));
        // largest value that still fits
        dir_rows.push_back(mk_row("6", 1'b1, 2'd0, '0, '0));
        dir_rows.push_back(mk_row("5", 1'b1, 2'd0, '0, '0));
        dir_rows.push_back(mk_row("5", 1'b1, 2'd0, '0, '0));
        dir_rows.push_back(mk_row("3", 1'b1, 2'd0, '0, '0));
        dir_rows.push_back(mk_row("5", 1'b1, 2'd0, '0, '0));
        dir_rows.push_back(mk_row(SEP_COMMA, 1'b1, 2'd1,
                                  mk_res(16'd65535, 6'd0, 7'd1, 1'b0), '0));
        // one past the limit: dropped
        dir_rows.push_back(mk_row("6", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row("5", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row("5", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row("3", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row("6", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row(SEP_SPACE, 1'b1, 2'd0, '0, '0));
        // zero token: dropped
        dir_rows.push_back(mk_row("0", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row("0", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row(SEP_TAB, 1'b1, 2'd0, '0, '0));
        // characters just outside the digit range end tokens
        dir_rows.push_back(mk_row("/", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row("9", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row(":", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row(8'hFF, 1'b0, 2'd0, '0, '0));
        // pending token at line end: value word, then summary
        dir_rows.push_back(mk_row("1", 1'b0, 2'd0, '0, '0));
        dir_rows.push_back(mk_row(dlp_pkg::CHAR_EOL, 1'b0, 2'd0, '0, '0));

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) send_row(dir_rows[i]);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 29;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 29;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < RAND_PER_PHASE) begin
                build_line();
                foreach (line_chars[k]) send_row(mk_row(line_chars[k], 1'b0, 2'd0, '0, '0));
                sent += line_chars.size();
            end
        end
        i_valid <= 1'b0;

        while (parsed_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (err_cnt == 0)
            $display("** decimal_list_parser_core: PASSED **");
        else
            $display("** decimal_list_parser_core: FAILED **");
        $finish;
    end

endmodule
